>>> src/dwml_pkg.sv
// Package: shared types, constants and the sequencer microcode for the depth window locator.
`timescale 1ns / 1ps
`default_nettype none
package dwml_pkg;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_COEFF  = 2'd0,
    KIND_CIRCLE = 2'd1,
    KIND_PIXEL  = 2'd2
  } kind_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_FX_INV = 3'd0,
    CFG_FY_INV = 3'd1,
    CFG_PX     = 3'd2,
    CFG_PY     = 3'd3,
    CFG_MOTION = 3'd4,
    CFG_RANGE  = 3'd5
  } cfg_idx_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int TBL_DEPTH  = 12;
  localparam int TBL_IDX_W  = 4;
  localparam int COEFF_W    = 32;
  localparam int WORLD_W    = 20;
  localparam int CAM_W      = 32;
  localparam int OPW        = 33;
  localparam int PRODW      = 66;
  localparam int ACCW       = 67;
  localparam int P1W        = 42;
  localparam int PIX_W      = 15;
  localparam int STEP_W     = 6;
  localparam logic [STEP_W-1:0] CAM_STEPS = 6'd14;
  localparam logic [STEP_W-1:0] LAST_STEP = 6'd37;

  localparam logic [23:0] RST_FX_INV = 24'd27962;
  localparam logic [23:0] RST_FY_INV = 24'd27962;
  localparam logic [15:0] RST_PX     = 16'd10240;
  localparam logic [15:0] RST_PY     = 16'd5760;
  localparam logic [15:0] RST_MOTION = 16'd10;
  localparam logic [15:0] RST_RANGE  = 16'd3000;

  typedef enum logic [2:0] {A_DX, A_DY, A_LO, A_HI, A_TBL} a_sel_t;
  typedef enum logic [2:0] {B_FX, B_FY, B_Z, B_CX, B_CY, B_CZ} b_sel_t;
  typedef enum logic [2:0] {ACC_NONE, ACC_CLR, ACC_LOAD, ACC_ADD, ACC_ADD_SH} acc_op_t;
  typedef enum logic [1:0] {RND_NONE, RND_CX, RND_CY, RND_W} rnd_op_t;
  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} ctrl_st_t;

  typedef struct packed {
    a_sel_t                 a_sel;
    b_sel_t                 b_sel;
    logic                   mul_en;
    logic                   p1_ld;
    acc_op_t                acc_op;
    logic                   abs_en;
    rnd_op_t                rnd_op;
    logic [TBL_IDX_W-1:0]   tbl_idx;
    logic [1:0]             row;
  } ucmd_t;

  typedef struct packed {
    logic  accept;
    logic  finish;
    ucmd_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic go;
    logic out_free;
  } dp_sts_t;

  localparam ucmd_t UCMD_NOP = '{a_sel: A_DX, b_sel: B_FX, mul_en: 1'b0, p1_ld: 1'b0,
                                 acc_op: ACC_NONE, abs_en: 1'b0, rnd_op: RND_NONE,
                                 tbl_idx: '0, row: '0};

  // Microcode: two camera axes of seven steps, then three world rows of eight steps.
  function automatic ucmd_t ucode(logic [STEP_W-1:0] step);
    ucmd_t              c;
    logic               ax;
    logic [2:0]         s;
    logic [STEP_W-1:0]  w;
    logic [1:0]         r;
    logic [TBL_IDX_W-1:0] base;
    c    = UCMD_NOP;
    ax   = 1'b0;
    s    = 3'd0;
    w    = '0;
    r    = 2'd0;
    base = '0;
    if (step < CAM_STEPS) begin
      ax = (step >= 6'd7);
      s  = ax ? 3'(step - 6'd7) : 3'(step);
      case (s)
        3'd0: begin
          c.a_sel  = ax ? A_DY : A_DX;
          c.b_sel  = ax ? B_FY : B_FX;
          c.mul_en = 1'b1;
        end
        3'd1: c.p1_ld = 1'b1;
        3'd2: begin
          c.a_sel = A_LO; c.b_sel = B_Z; c.mul_en = 1'b1; c.acc_op = ACC_CLR;
        end
        3'd3: begin
          c.a_sel = A_HI; c.b_sel = B_Z; c.mul_en = 1'b1; c.acc_op = ACC_ADD;
        end
        3'd4: c.acc_op = ACC_ADD_SH;
        3'd5: c.abs_en = 1'b1;
        3'd6: c.rnd_op = ax ? RND_CY : RND_CX;
        default: c = UCMD_NOP;
      endcase
    end else begin
      w    = step - CAM_STEPS;
      s    = w[2:0];
      r    = w[4:3];
      base = {r, 2'b00};
      c.row = r;
      case (s)
        3'd0: c.tbl_idx = base + 4'd3;
        3'd1: begin
          c.acc_op = ACC_LOAD; c.tbl_idx = base;
        end
        3'd2: begin
          c.a_sel = A_TBL; c.b_sel = B_CX; c.mul_en = 1'b1; c.tbl_idx = base + 4'd1;
        end
        3'd3: begin
          c.a_sel = A_TBL; c.b_sel = B_CY; c.mul_en = 1'b1; c.tbl_idx = base + 4'd2;
          c.acc_op = ACC_ADD;
        end
        3'd4: begin
          c.a_sel = A_TBL; c.b_sel = B_CZ; c.mul_en = 1'b1; c.acc_op = ACC_ADD;
        end
        3'd5: c.acc_op = ACC_ADD;
        3'd6: c.abs_en = 1'b1;
        3'd7: c.rnd_op = RND_W;
        default: c = UCMD_NOP;
      endcase
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/dwml_in_if.sv
// Interface: input item channel carrying coefficients, circles and depth pixels.
`timescale 1ns / 1ps
`default_nettype none
interface dwml_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  coeff_index;
  logic signed [31:0] coeff_value;
  logic [11:0] circle_x;
  logic [11:0] circle_y;
  logic [11:0] radius;
  logic [11:0] pixel_col;
  logic [11:0] pixel_row;
  logic [15:0] depth;
  logic        frame_last;

  modport source (output valid, kind, coeff_index, coeff_value, circle_x, circle_y, radius,
                  pixel_col, pixel_row, depth, frame_last, input ready);
  modport sink (input valid, kind, coeff_index, coeff_value, circle_x, circle_y, radius,
                pixel_col, pixel_row, depth, frame_last, output ready);
endinterface
`default_nettype wire

>>> src/dwml_out_if.sv
// Interface: result item channel carrying the world point and flags.
`timescale 1ns / 1ps
`default_nettype none
interface dwml_out_if;
  logic        valid;
  logic        ready;
  logic signed [19:0] world_x;
  logic signed [19:0] world_y;
  logic signed [19:0] world_z;
  logic [15:0] camera_z;
  logic        moving;
  logic        publish;

  modport source (output valid, world_x, world_y, world_z, camera_z, moving, publish,
                  input ready);
  modport sink (input valid, world_x, world_y, world_z, camera_z, moving, publish,
                output ready);
endinterface
`default_nettype wire

>>> src/dwml_ctrl.sv
// Controller: accepts items and steps the frame-end sequencer through its microcode.
`timescale 1ns / 1ps
`default_nettype none
module dwml_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dwml_pkg::dp_sts_t sts,
  output dwml_pkg::dp_cmd_t      cmd
);

  dwml_pkg::ctrl_st_t                 st_r, st_nxt;
  logic [dwml_pkg::STEP_W-1:0]        step_r, step_nxt;
  logic                               accept;

  assign in_ready = (st_r == dwml_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and step count.
  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    case (st_r)
      dwml_pkg::ST_IDLE: begin
        if (accept && sts.go) begin
          st_nxt   = dwml_pkg::ST_RUN;
          step_nxt = '0;
        end
      end
      dwml_pkg::ST_RUN: begin
        if (step_r == dwml_pkg::LAST_STEP) begin
          st_nxt = dwml_pkg::ST_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      dwml_pkg::ST_DONE: begin
        if (sts.out_free) begin
          st_nxt = dwml_pkg::ST_IDLE;
        end
      end
      default: st_nxt = dwml_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd.accept = accept;
    cmd.finish = 1'b0;
    cmd.op     = dwml_pkg::UCMD_NOP;
    case (st_r)
      dwml_pkg::ST_IDLE: cmd.op = dwml_pkg::UCMD_NOP;
      dwml_pkg::ST_RUN:  cmd.op = dwml_pkg::ucode(step_r);
      dwml_pkg::ST_DONE: cmd.finish = sts.out_free;
      default:           cmd.op = dwml_pkg::UCMD_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= dwml_pkg::ST_IDLE;
      step_r <= '0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
    end
  end

  // The sequencer never runs past its last microcode step.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == dwml_pkg::ST_RUN |-> step_r <= dwml_pkg::LAST_STEP)
    else $error("sequencer step out of range");

  // A qualifying last pixel starts the sequencer at its first step.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && sts.go |=> st_r == dwml_pkg::ST_RUN && step_r == '0)
    else $error("frame end did not start the sequencer");

  // The last step always hands over to the result stage.
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == dwml_pkg::ST_RUN && step_r == dwml_pkg::LAST_STEP |=> st_r == dwml_pkg::ST_DONE)
    else $error("sequencer did not reach result stage");

endmodule
`default_nettype wire

>>> src/dwml_datapath.sv
// Datapath: frame window tracking, shared multiplier, accumulator, rounding and motion check.
`timescale 1ns / 1ps
`default_nettype none
module dwml_datapath #(
  parameter int COORD_BITS = 12,
  parameter int DEPTH_BITS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire dwml_pkg::dp_cmd_t                  cmd,
  output dwml_pkg::dp_sts_t                       sts,
  input  wire logic                               cfg_we,
  input  wire logic [dwml_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dwml_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                               in_valid,
  input  wire logic [1:0]                         in_kind,
  input  wire logic [3:0]                         in_coeff_index,
  input  wire logic signed [31:0]                 in_coeff_value,
  input  wire logic [11:0]                        in_circle_x,
  input  wire logic [11:0]                        in_circle_y,
  input  wire logic [11:0]                        in_radius,
  input  wire logic [11:0]                        in_pixel_col,
  input  wire logic [11:0]                        in_pixel_row,
  input  wire logic [15:0]                        in_depth,
  input  wire logic                               in_frame_last,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [19:0]                      out_world_x,
  output logic signed [19:0]                      out_world_y,
  output logic signed [19:0]                      out_world_z,
  output logic [15:0]                             out_camera_z,
  output logic                                    out_moving,
  output logic                                    out_publish
);

  localparam int PW = dwml_pkg::PIX_W;
  localparam int AW = dwml_pkg::ACCW;
  localparam int WW = dwml_pkg::WORLD_W;
  localparam logic [PW-1:0] IMG_MAX = PW'((32'd1 << COORD_BITS) - 32'd1);
  localparam logic [15:0]   DMASK   = 16'((32'd1 << DEPTH_BITS) - 32'd1);

  // Configuration registers.
  logic [23:0] fx_r, fy_r;
  logic [15:0] px_r, py_r, thr_r, range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r    <= dwml_pkg::RST_FX_INV;
      fy_r    <= dwml_pkg::RST_FY_INV;
      px_r    <= dwml_pkg::RST_PX;
      py_r    <= dwml_pkg::RST_PY;
      thr_r   <= dwml_pkg::RST_MOTION;
      range_r <= dwml_pkg::RST_RANGE;
    end else if (cfg_we) begin
      case (dwml_pkg::cfg_idx_t'(cfg_index))
        dwml_pkg::CFG_FX_INV: fx_r    <= cfg_wdata;
        dwml_pkg::CFG_FY_INV: fy_r    <= cfg_wdata;
        dwml_pkg::CFG_PX:     px_r    <= cfg_wdata[15:0];
        dwml_pkg::CFG_PY:     py_r    <= cfg_wdata[15:0];
        dwml_pkg::CFG_MOTION: thr_r   <= cfg_wdata[15:0];
        dwml_pkg::CFG_RANGE:  range_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Frame window state.
  logic [11:0] cx_r, cy_r, rad_r;
  logic [15:0] cdep_r, wmin_r, z_r;
  logic [PW-1:0] left, right, top, bottom, rr_raw, br_raw, col_w, row_w;
  logic [15:0] dm, cdep_upd, wmin_upd;
  logic        in_img, is_pixel;

  always_comb begin
    left   = (cx_r >= rad_r) ? PW'(cx_r - rad_r) : '0;
    top    = (cy_r >= rad_r) ? PW'(cy_r - rad_r) : '0;
    rr_raw = PW'(cx_r) + PW'(rad_r);
    br_raw = PW'(cy_r) + PW'(rad_r);
    right  = (rr_raw > IMG_MAX) ? IMG_MAX : rr_raw;
    bottom = (br_raw > IMG_MAX) ? IMG_MAX : br_raw;
    col_w  = PW'(in_pixel_col);
    row_w  = PW'(in_pixel_row);
    in_img = (col_w <= IMG_MAX) && (row_w <= IMG_MAX);
    dm     = in_depth & DMASK;
    cdep_upd = cdep_r;
    wmin_upd = wmin_r;
    if (in_img) begin
      if (in_pixel_col == cx_r && in_pixel_row == cy_r) cdep_upd = dm;
      if (col_w >= left && col_w <= right && row_w >= top && row_w <= bottom &&
          dm > 16'd1 && dm < wmin_r) wmin_upd = dm;
    end
  end

  assign is_pixel = (dwml_pkg::kind_t'(in_kind) == dwml_pkg::KIND_PIXEL);
  assign sts      = '{go:       in_valid && is_pixel && in_frame_last && (rad_r > 12'd1),
                      out_free: !out_valid || out_ready};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      rad_r  <= '0;
      cdep_r <= '0;
      wmin_r <= DMASK;
    end else if (cmd.accept) begin
      case (dwml_pkg::kind_t'(in_kind))
        dwml_pkg::KIND_CIRCLE: begin
          cx_r   <= in_circle_x;
          cy_r   <= in_circle_y;
          rad_r  <= in_radius;
          cdep_r <= '0;
          wmin_r <= DMASK;
        end
        dwml_pkg::KIND_PIXEL: begin
          if (in_frame_last) begin
            cdep_r <= '0;
            wmin_r <= DMASK;
          end else begin
            cdep_r <= cdep_upd;
            wmin_r <= wmin_upd;
          end
        end
        default: ;
      endcase
    end
  end

  // Chosen depth for the frame.
  always_ff @(posedge clk) begin
    if (cmd.accept && is_pixel && in_frame_last) begin
      z_r <= (cdep_upd < wmin_upd) ? cdep_upd : wmin_upd;
    end
  end

  // Transform coefficient memory with a valid bit per entry.
  logic signed [31:0] tbl_mem [dwml_pkg::TBL_DEPTH];
  logic [dwml_pkg::TBL_DEPTH-1:0] tvalid_r;
  logic signed [31:0] trd_r, tval;
  logic               trdv_r;
  logic               twr;

  assign twr = cmd.accept && (dwml_pkg::kind_t'(in_kind) == dwml_pkg::KIND_COEFF) &&
               (in_coeff_index < 4'(dwml_pkg::TBL_DEPTH));

  always_ff @(posedge clk) begin
    if (twr) tbl_mem[in_coeff_index] <= in_coeff_value;
    trd_r <= tbl_mem[cmd.op.tbl_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= '0;
      trdv_r   <= 1'b0;
    end else begin
      if (twr) tvalid_r[in_coeff_index] <= 1'b1;
      trdv_r <= tvalid_r[cmd.op.tbl_idx];
    end
  end

  assign tval = trdv_r ? trd_r : '0;

  // Shared multiplier operands.
  logic signed [16:0] dx, dy;
  logic signed [dwml_pkg::P1W-1:0]   p1_r;
  logic signed [dwml_pkg::OPW-1:0]   op_a, op_b;
  logic signed [dwml_pkg::PRODW-1:0] prod_r;
  logic signed [dwml_pkg::CAM_W-1:0] camx_r, camy_r;

  assign dx = $signed({1'b0, cx_r, 4'b0000}) - $signed({1'b0, px_r});
  assign dy = $signed({1'b0, cy_r, 4'b0000}) - $signed({1'b0, py_r});

  always_comb begin
    case (cmd.op.a_sel)
      dwml_pkg::A_DX:  op_a = dwml_pkg::OPW'(dx);
      dwml_pkg::A_DY:  op_a = dwml_pkg::OPW'(dy);
      dwml_pkg::A_LO:  op_a = $signed({9'b0, p1_r[23:0]});
      dwml_pkg::A_HI:  op_a = dwml_pkg::OPW'($signed(p1_r[dwml_pkg::P1W-1:24]));
      dwml_pkg::A_TBL: op_a = dwml_pkg::OPW'(tval);
      default:         op_a = '0;
    endcase
    case (cmd.op.b_sel)
      dwml_pkg::B_FX: op_b = $signed({9'b0, fx_r});
      dwml_pkg::B_FY: op_b = $signed({9'b0, fy_r});
      dwml_pkg::B_Z:  op_b = $signed({17'b0, z_r});
      dwml_pkg::B_CX: op_b = dwml_pkg::OPW'(camx_r);
      dwml_pkg::B_CY: op_b = dwml_pkg::OPW'(camy_r);
      dwml_pkg::B_CZ: op_b = $signed({9'b0, z_r, 8'b0});
      default:        op_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op.mul_en) prod_r <= op_a * op_b;
    if (cmd.op.p1_ld)  p1_r   <= dwml_pkg::P1W'(prod_r);
  end

  // Accumulator and magnitude stage.
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic [AW-1:0]        mag_r;
  logic                 neg_r;

  always_comb begin
    case (cmd.op.acc_op)
      dwml_pkg::ACC_CLR:    acc_nxt = '0;
      dwml_pkg::ACC_LOAD:   acc_nxt = AW'(tval) <<< 8;
      dwml_pkg::ACC_ADD:    acc_nxt = acc_r + AW'(prod_r);
      dwml_pkg::ACC_ADD_SH: acc_nxt = acc_r + (AW'(prod_r) <<< 24);
      default:              acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.op.abs_en) begin
      neg_r <= acc_r[AW-1];
      mag_r <= acc_r[AW-1] ? $unsigned(-acc_r) : $unsigned(acc_r);
    end
  end

  // Rounding to nearest, ties away from zero, with saturation on the magnitude.
  logic [AW-1:0] rc, rw;
  logic [30:0]   mc;
  logic [20:0]   mw, limw;
  logic signed [dwml_pkg::CAM_W-1:0] cam_val;
  logic signed [WW-1:0] w_val;

  always_comb begin
    rc      = (mag_r + (AW'(1) << 19)) >> 20;
    mc      = (rc > AW'(32'h4000_0000)) ? 31'h4000_0000 : rc[30:0];
    cam_val = neg_r ? -$signed({1'b0, mc}) : $signed({1'b0, mc});
    rw      = (mag_r + (AW'(1) << 23)) >> 24;
    limw    = neg_r ? 21'd524288 : 21'd524287;
    mw      = (rw > AW'(limw)) ? limw : rw[20:0];
    w_val   = neg_r ? WW'(-$signed(mw)) : WW'(mw);
  end

  logic signed [WW-1:0] world_r [3];
  logic signed [WW-1:0] last_r  [3];

  always_ff @(posedge clk) begin
    case (cmd.op.rnd_op)
      dwml_pkg::RND_CX: camx_r <= cam_val;
      dwml_pkg::RND_CY: camy_r <= cam_val;
      dwml_pkg::RND_W:  world_r[cmd.op.row] <= w_val;
      default: ;
    endcase
  end

  // Motion test against the last kept position.
  logic [2:0]  ax_move;
  logic        moving;
  logic signed [WW:0] diff [3];
  logic [WW:0] adiff [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]    = (WW+1)'(world_r[i]) - (WW+1)'(last_r[i]);
      adiff[i]   = diff[i][WW] ? $unsigned(-diff[i]) : $unsigned(diff[i]);
      ax_move[i] = adiff[i] > (WW+1)'(thr_r);
    end
    moving = |ax_move;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) last_r[i] <= '0;
    end else if (cmd.finish && moving) begin
      for (int i = 0; i < 3; i++) last_r[i] <= world_r[i];
    end
  end

  // Output register.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_world_x  <= world_r[0];
      out_world_y  <= world_r[1];
      out_world_z  <= world_r[2];
      out_camera_z <= z_r;
      out_moving   <= moving;
      out_publish  <= moving && (z_r != 16'd0) && (z_r < range_r);
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> src/depth_window_min_locate_unit.sv
// Top level: depth window minimum locator with back-projection and rigid transform.
//
//  Channel   Direction  Handshake      Carries
//  in_ch     sink       valid / ready  coefficient, circle or depth pixel item
//  out_ch    source     valid / ready  world point, chosen depth, moving and publish
//  cfg_*     sink       write enable   intrinsics, motion threshold, range limit
//
// Coefficient, circle and ordinary pixel items are absorbed on acceptance, back to back in idle.
// A last pixel with radius above one runs a 38-step sequence around the single shared
// 33x33 multiplier and accumulator, then the done state loads the output register.
// While the sequence runs no item is accepted; in idle items are taken even with a result held.
// A stalled result holds the done state until the output register is free. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module depth_window_min_locate_unit #(
  parameter int COORD_BITS = 12,
  parameter int DEPTH_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  dwml_in_if.sink                              in_ch,
  dwml_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [dwml_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dwml_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  dwml_pkg::dp_cmd_t cmd;
  dwml_pkg::dp_sts_t sts;

  // Sequencer.
  dwml_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and state.
  dwml_datapath #(
    .COORD_BITS (COORD_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_ch.valid),
    .in_kind        (in_ch.kind),
    .in_coeff_index (in_ch.coeff_index),
    .in_coeff_value (in_ch.coeff_value),
    .in_circle_x    (in_ch.circle_x),
    .in_circle_y    (in_ch.circle_y),
    .in_radius      (in_ch.radius),
    .in_pixel_col   (in_ch.pixel_col),
    .in_pixel_row   (in_ch.pixel_row),
    .in_depth       (in_ch.depth),
    .in_frame_last  (in_ch.frame_last),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_world_x    (out_ch.world_x),
    .out_world_y    (out_ch.world_y),
    .out_world_z    (out_ch.world_z),
    .out_camera_z   (out_ch.camera_z),
    .out_moving     (out_ch.moving),
    .out_publish    (out_ch.publish)
  );

endmodule
`default_nettype wire
